>>> hw/rtl/bbmc_pkg.sv
// bbmc_pkg: shared widths, constants, register indexes, sequencer types
// and the request/response structs of the bit-serial arithmetic units.
// No dependencies.
package bbmc_pkg;

    // field widths
    localparam int PITCH_W   = 17;
    localparam int RAW16_W   = 16;
    localparam int BATT_W    = 12;
    localparam int DUTY_A_W  = 14;
    localparam int DUTY_B_W  = 12;
    localparam int SERVO_W   = 16;
    localparam int GAIN_W    = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_SETP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_TGT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_EN     = 3'd7;

    // arithmetic units
    localparam int ACC_W     = 64;
    localparam int MUL_W     = 24;
    localparam int MUL_CNT_W = 5;
    localparam int DIV_W     = 40;
    localparam int DIV_CNT_W = 6;
    localparam int DVSR_W    = 7;

    localparam logic [DVSR_W-1:0] FILT_DIVISOR = 7'd10;
    localparam logic [DVSR_W-1:0] VEL_DIVISOR  = 7'd100;
    localparam int VEL_SHIFT   = 23;
    localparam int ANGLE_SHIFT = 16;

    // loop limits
    localparam int ANGLE_INT_LIM = 7680;
    localparam int SPEED_INT_LIM = 8192000;
    localparam int DUTY_A_LIM    = 8000;
    localparam int DUTY_A_TRIM   = 3;
    localparam int DUTY_A_DEAD   = 1000;
    localparam int REAR_LIM      = 7000;
    localparam int REAR_KP       = 12;
    localparam int REAR_KI       = 20;
    localparam int DIV5_RECIP    = 52429;
    localparam int DIV5_SHIFT    = 18;
    localparam int BATT_MIN      = 2500;
    localparam int TILT_LIM      = 5120;
    localparam int SERVO_LIMIT   = 300;
    localparam int SERVO_CENTER  = 1500;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        STEP_KP,
        STEP_KI,
        STEP_KD,
        STEP_FDIV,
        STEP_SKP,
        STEP_X100,
        STEP_SKI,
        STEP_VDIV
    } step_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/bbmc_ifs.sv
// bbmc_ifs: valid/ready channel interfaces for the sample and result words.
// Depends on bbmc_pkg for field widths.
interface bbmc_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bbmc_pkg::PITCH_W-1:0]  pitch_angle;
    logic signed [bbmc_pkg::RAW16_W-1:0]  gyro_rate;
    logic signed [bbmc_pkg::RAW16_W-1:0]  encoder_a;
    logic signed [bbmc_pkg::RAW16_W-1:0]  encoder_b;
    logic        [bbmc_pkg::BATT_W-1:0]   battery_level;
    logic signed [bbmc_pkg::RAW16_W-1:0]  steer_request;

    modport source (output valid, pitch_angle, gyro_rate, encoder_a, encoder_b,
                    battery_level, steer_request, input ready);
    modport sink   (input valid, pitch_angle, gyro_rate, encoder_a, encoder_b,
                    battery_level, steer_request, output ready);
endinterface

interface bbmc_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bbmc_pkg::DUTY_A_W-1:0]  duty_a;
    logic signed [bbmc_pkg::DUTY_B_W-1:0]  duty_b;
    logic        [bbmc_pkg::SERVO_W-1:0]   servo_pulse;
    logic                                  stopped;

    modport source (output valid, duty_a, duty_b, servo_pulse, stopped, input ready);
    modport sink   (input valid, duty_a, duty_b, servo_pulse, stopped, output ready);
endinterface

>>> hw/rtl/bbmc_smul.sv
// bbmc_smul: bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on bbmc_pkg (widths, mul_req_t, mul_rsp_t).
module bbmc_smul (
    input  logic               clk,
    input  logic               rst_n,
    input  bbmc_pkg::mul_req_t req,
    output bbmc_pkg::mul_rsp_t rsp
);

    logic signed [bbmc_pkg::ACC_W-1:0]  mcand_reg;
    logic        [bbmc_pkg::MUL_W-1:0]  mplier_reg;
    logic signed [bbmc_pkg::ACC_W-1:0]  prod_reg;
    logic        [bbmc_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                               run_reg;
    logic                               done_reg;
    logic                               last_c;
    logic signed [bbmc_pkg::ACC_W-1:0]  prod_next;

    // top bit of a two's complement multiplier carries negative weight
    assign last_c = (cnt_reg == bbmc_pkg::MUL_CNT_W'(bbmc_pkg::MUL_W - 1));

    always_comb
    begin
        prod_next = prod_reg;
        if (mplier_reg[0])
        begin
            if (last_c)
                prod_next = prod_reg - mcand_reg;
            else
                prod_next = prod_reg + mcand_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_c)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift and add datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg  <= req.a;
            mplier_reg <= req.b;
            prod_reg   <= '0;
        end
        else if (run_reg)
        begin
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
            prod_reg   <= prod_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = prod_reg;

endmodule

>>> hw/rtl/bbmc_cdiv.sv
// bbmc_cdiv: bit-serial restoring divider for small unsigned divisors,
// one quotient bit per cycle. Depends on bbmc_pkg (widths, div_req_t, div_rsp_t).
module bbmc_cdiv (
    input  logic               clk,
    input  logic               rst_n,
    input  bbmc_pkg::div_req_t req,
    output bbmc_pkg::div_rsp_t rsp
);

    logic [bbmc_pkg::DIV_W-1:0]     quo_reg;
    logic [bbmc_pkg::DVSR_W-1:0]    rem_reg;
    logic [bbmc_pkg::DVSR_W-1:0]    dvsr_reg;
    logic [bbmc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           run_reg;
    logic                           done_reg;
    logic [bbmc_pkg::DVSR_W:0]      trial_c;
    logic                           ge_c;

    // trial subtract of the next dividend bit
    assign trial_c = {rem_reg, quo_reg[bbmc_pkg::DIV_W-1]};
    assign ge_c    = (trial_c >= {1'b0, dvsr_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bbmc_pkg::DIV_CNT_W'(bbmc_pkg::DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[bbmc_pkg::DIV_W-2:0], ge_c};
            if (ge_c)
                rem_reg <= bbmc_pkg::DVSR_W'(trial_c - {1'b0, dvsr_reg});
            else
                rem_reg <= trial_c[bbmc_pkg::DVSR_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hw/rtl/balance_bike_motor_controller.sv
// balance_bike_motor_controller: cascaded angle/velocity PID, rear PI and servo
// clamp. Depends on bbmc_pkg, bbmc_ifs, bbmc_smul and bbmc_cdiv.
//
//   channel  | dir | handshake     | payload
//   sample   | in  | valid / ready | pitch, gyro, encoders, battery, steer
//   result   | out | valid / ready | duty_a, duty_b, servo_pulse, stopped
//   cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// each word runs six products on the bit-serial multiplier
// (start, one step per multiplier bit, hand-off), two quotients on the bit-serial
// divider (start, one step per dividend bit, hand-off), one accept, one finish
// one word is in work at a time; ready is high only when the sequencer is idle
// the result register holds a word under stall; the next word is taken while
// it waits, and the sequencer holds in its last step until the register frees
// reset clears loop state and restores the register defaults
module balance_bike_motor_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    bbmc_sample_if.sink                         sample,
    bbmc_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [bbmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic signed [23:0] angle_kp_reg, angle_ki_reg, angle_kd_reg;
    logic signed [23:0] speed_kp_reg, speed_ki_reg;
    logic signed [16:0] setp_reg;
    logic signed [15:0] target_reg;
    logic               run_reg;

    // loop state
    logic signed [15:0] angle_int_reg;
    logic signed [31:0] filt_reg;
    logic signed [23:0] sint_reg;
    logic signed [13:0] racc_reg;
    logic signed [15:0] rlast_reg;

    // sequencer
    bbmc_pkg::state_t state_reg, state_next;
    bbmc_pkg::step_t  step_reg, step_next;
    logic             accept_c;
    logic             load_out_c;
    logic             res_valid_reg;

    // word datapath
    logic signed [15:0] gyro_reg, enc_a_reg, steer_reg;
    logic signed [17:0] bias_reg;
    logic signed [15:0] ai_reg;
    logic               stop_reg;
    logic signed [63:0] acc_reg;
    logic signed [39:0] ang_reg;
    logic signed [39:0] vel_reg;
    logic signed [31:0] f_reg;
    logic signed [23:0] si_reg;
    logic               neg_reg;

    // result register
    logic signed [13:0] duty_a_reg;
    logic signed [11:0] duty_b_reg;
    logic        [15:0] pulse_reg;
    logic               stopped_reg;

    bbmc_pkg::mul_req_t mul_req;
    bbmc_pkg::mul_rsp_t mul_rsp;
    bbmc_pkg::div_req_t div_req;
    bbmc_pkg::div_rsp_t div_rsp;

    bbmc_smul u_smul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
    bbmc_cdiv u_cdiv (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // angle error and clamped integral
    logic signed [17:0] bias_c;
    logic signed [18:0] ai_sum_c;
    logic signed [15:0] ai_c;
    logic               stop_c;

    assign bias_c   = 18'(sample.pitch_angle) - 18'(setp_reg);
    assign ai_sum_c = 19'(angle_int_reg) + 19'(bias_c);

    always_comb
    begin
        priority if (ai_sum_c > 19'(bbmc_pkg::ANGLE_INT_LIM))
            ai_c = 16'(bbmc_pkg::ANGLE_INT_LIM);
        else if (ai_sum_c < 19'(-bbmc_pkg::ANGLE_INT_LIM))
            ai_c = 16'(-bbmc_pkg::ANGLE_INT_LIM);
        else
            ai_c = 16'(ai_sum_c);
    end

    assign stop_c = (sample.battery_level < 12'(bbmc_pkg::BATT_MIN))
                 || (sample.pitch_angle > 17'(bbmc_pkg::TILT_LIM))
                 || (sample.pitch_angle < 17'(-bbmc_pkg::TILT_LIM));

    // rear incremental pi
    logic signed [16:0] rdiff_c;
    logic signed [15:0] rb_c;
    logic signed [23:0] rsum_c;
    logic signed [13:0] racc_c;

    assign rdiff_c = 17'(sample.encoder_b) - 17'(target_reg);

    always_comb
    begin
        priority if (rdiff_c > 17'sd32767)
            rb_c = 16'sh7FFF;
        else if (rdiff_c < -17'sd32768)
            rb_c = 16'sh8000;
        else
            rb_c = 16'(rdiff_c);
    end

    assign rsum_c = 24'(racc_reg)
                  + 24'(bbmc_pkg::REAR_KP) * (24'(rb_c) - 24'(rlast_reg))
                  + 24'(bbmc_pkg::REAR_KI) * 24'(rb_c);

    always_comb
    begin
        priority if (rsum_c > 24'(bbmc_pkg::REAR_LIM))
            racc_c = 14'(bbmc_pkg::REAR_LIM);
        else if (rsum_c < 24'(-bbmc_pkg::REAR_LIM))
            racc_c = 14'(-bbmc_pkg::REAR_LIM);
        else
            racc_c = 14'(rsum_c);
    end

    // multiplier operands
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (step_reg)
            bbmc_pkg::STEP_KP:
            begin
                mul_req.a = 64'(bias_reg);
                mul_req.b = angle_kp_reg;
            end
            bbmc_pkg::STEP_KI:
            begin
                mul_req.a = 64'(ai_reg);
                mul_req.b = angle_ki_reg;
            end
            bbmc_pkg::STEP_KD:
            begin
                mul_req.a = 64'(gyro_reg);
                mul_req.b = angle_kd_reg;
            end
            bbmc_pkg::STEP_SKP:
            begin
                mul_req.a = 64'(f_reg);
                mul_req.b = speed_kp_reg;
            end
            bbmc_pkg::STEP_X100:
            begin
                mul_req.a = acc_reg;
                mul_req.b = 24'(bbmc_pkg::VEL_DIVISOR);
            end
            bbmc_pkg::STEP_SKI:
            begin
                mul_req.a = 64'(si_reg);
                mul_req.b = speed_ki_reg;
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
        if (state_reg == bbmc_pkg::ST_MUL_GO)
            mul_req.start = 1'b1;
    end

    // filter numerator 7*f + 3*(e << 15) and velocity magnitude
    logic signed [16:0] e_c;
    logic signed [39:0] fnum_c;
    logic        [39:0] fabs_c;
    logic        [63:0] vabs_c;

    assign e_c    = 17'sd0 - 17'(enc_a_reg);
    assign fnum_c = (40'(filt_reg) <<< 3) - 40'(filt_reg)
                  + (40'(e_c) <<< 16) + (40'(e_c) <<< 15);
    assign fabs_c = fnum_c[39] ? 40'(-fnum_c) : 40'(fnum_c);
    assign vabs_c = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);

    always_comb
    begin
        div_req.start = (state_reg == bbmc_pkg::ST_DIV_GO);
        if (step_reg == bbmc_pkg::STEP_FDIV)
        begin
            div_req.dividend = fabs_c;
            div_req.divisor  = bbmc_pkg::FILT_DIVISOR;
        end
        else
        begin
            div_req.dividend = vabs_c[bbmc_pkg::VEL_SHIFT +: bbmc_pkg::DIV_W];
            div_req.divisor  = bbmc_pkg::VEL_DIVISOR;
        end
    end

    // signed quotient, truncated toward zero
    logic signed [39:0] q_s;
    logic signed [39:0] qs_c;

    assign q_s  = $signed(div_rsp.quotient);
    assign qs_c = neg_reg ? -q_s : q_s;

    // angle term sums
    logic signed [63:0] asum_c;
    logic signed [63:0] vsum_c;
    logic signed [39:0] ang_c;

    assign asum_c = acc_reg + (mul_rsp.product <<< 8);
    assign vsum_c = acc_reg + (mul_rsp.product <<< 3);
    assign ang_c  = 40'((asum_c + (asum_c[63] ? 64'sd65535 : 64'sd0))
                        >>> bbmc_pkg::ANGLE_SHIFT);

    // velocity integral from the filtered speed
    logic signed [31:0] f8_c;
    logic signed [29:0] si_sum_c;
    logic signed [23:0] si_c;

    assign f8_c     = (f_reg + (f_reg[31] ? 32'sd7 : 32'sd0)) >>> 3;
    assign si_sum_c = 30'(sint_reg) + 30'(f8_c);

    always_comb
    begin
        priority if (si_sum_c > 30'(bbmc_pkg::SPEED_INT_LIM))
            si_c = 24'(bbmc_pkg::SPEED_INT_LIM);
        else if (si_sum_c < 30'(-bbmc_pkg::SPEED_INT_LIM))
            si_c = 24'(-bbmc_pkg::SPEED_INT_LIM);
        else
            si_c = 24'(si_sum_c);
    end

    // motor a duty: saturate, trim, dead band
    logic signed [39:0] velu_c;
    logic signed [41:0] dsum_c;
    logic signed [13:0] trim_c;
    logic signed [13:0] da_c;

    assign velu_c = run_reg ? vel_reg : 40'sd0;
    assign dsum_c = 42'sd0 - 42'(ang_reg) - 42'(velu_c);

    always_comb
    begin
        priority if (dsum_c > 42'(bbmc_pkg::DUTY_A_LIM))
            trim_c = 14'(bbmc_pkg::DUTY_A_LIM);
        else if (dsum_c < 42'(-bbmc_pkg::DUTY_A_LIM))
            trim_c = 14'(-bbmc_pkg::DUTY_A_LIM);
        else if (dsum_c < 42'sd0)
            trim_c = 14'(dsum_c + 42'(bbmc_pkg::DUTY_A_TRIM));
        else if (dsum_c > 42'sd0)
            trim_c = 14'(dsum_c - 42'(bbmc_pkg::DUTY_A_TRIM));
        else
            trim_c = 14'sd0;

        if ((trim_c < 14'(bbmc_pkg::DUTY_A_DEAD)) && (trim_c > 14'(-bbmc_pkg::DUTY_A_DEAD)))
            da_c = 14'sd0;
        else
            da_c = trim_c;
    end

    // motor b duty: accumulator / 5 by reciprocal
    logic        [12:0] rabs_c;
    logic        [29:0] rq_c;
    logic        [11:0] q5_c;
    logic signed [11:0] db_c;

    assign rabs_c = racc_reg[13] ? 13'(-racc_reg) : 13'(racc_reg);
    assign rq_c   = 30'(rabs_c) * 30'(bbmc_pkg::DIV5_RECIP);
    assign q5_c   = rq_c[bbmc_pkg::DIV5_SHIFT +: 12];
    assign db_c   = racc_reg[13] ? $signed(12'd0 - q5_c) : $signed(q5_c);

    // servo clamp and centre
    logic signed [15:0] sc_c;
    logic signed [17:0] psum_c;
    logic        [15:0] pulse_c;

    always_comb
    begin
        priority if (steer_reg > 16'(bbmc_pkg::SERVO_LIMIT))
            sc_c = 16'(bbmc_pkg::SERVO_LIMIT);
        else if (steer_reg < 16'(-bbmc_pkg::SERVO_LIMIT))
            sc_c = 16'(-bbmc_pkg::SERVO_LIMIT);
        else
            sc_c = steer_reg;

        psum_c = 18'(bbmc_pkg::SERVO_CENTER) + 18'(sc_c);
        priority if (psum_c < 18'sd0)
            pulse_c = 16'd0;
        else if (psum_c > 18'sd65535)
            pulse_c = 16'hFFFF;
        else
            pulse_c = 16'(psum_c);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        accept_c   = 1'b0;
        load_out_c = 1'b0;
        unique case (state_reg)
            bbmc_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    accept_c   = 1'b1;
                    step_next  = bbmc_pkg::STEP_KP;
                    state_next = bbmc_pkg::ST_MUL_GO;
                end
            end
            bbmc_pkg::ST_MUL_GO:
                state_next = bbmc_pkg::ST_MUL_WAIT;
            bbmc_pkg::ST_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = bbmc_pkg::ST_MUL_GO;
                    unique case (step_reg)
                        bbmc_pkg::STEP_KP:   step_next = bbmc_pkg::STEP_KI;
                        bbmc_pkg::STEP_KI:   step_next = bbmc_pkg::STEP_KD;
                        bbmc_pkg::STEP_KD:
                        begin
                            step_next  = bbmc_pkg::STEP_FDIV;
                            state_next = bbmc_pkg::ST_DIV_GO;
                        end
                        bbmc_pkg::STEP_SKP:  step_next = bbmc_pkg::STEP_X100;
                        bbmc_pkg::STEP_X100: step_next = bbmc_pkg::STEP_SKI;
                        bbmc_pkg::STEP_SKI:
                        begin
                            step_next  = bbmc_pkg::STEP_VDIV;
                            state_next = bbmc_pkg::ST_DIV_GO;
                        end
                        default:             state_next = bbmc_pkg::ST_IDLE;
                    endcase
                end
            end
            bbmc_pkg::ST_DIV_GO:
                state_next = bbmc_pkg::ST_DIV_WAIT;
            bbmc_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (step_reg == bbmc_pkg::STEP_FDIV)
                    begin
                        step_next  = bbmc_pkg::STEP_SKP;
                        state_next = bbmc_pkg::ST_MUL_GO;
                    end
                    else
                        state_next = bbmc_pkg::ST_FINISH;
                end
            end
            bbmc_pkg::ST_FINISH:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_out_c = 1'b1;
                    state_next = bbmc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = bbmc_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbmc_pkg::ST_IDLE;
            step_reg  <= bbmc_pkg::STEP_KP;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_kp_reg <= 24'sd486400;
            angle_ki_reg <= -24'sd13261;
            angle_kd_reg <= 24'sd3840;
            speed_kp_reg <= 24'sd8192;
            speed_ki_reg <= 24'sd256;
            setp_reg     <= -17'sd179;
            target_reg   <= 16'sd30;
            run_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bbmc_pkg::REG_ANGLE_KP:   angle_kp_reg <= $signed(cfg_data);
                bbmc_pkg::REG_ANGLE_KI:   angle_ki_reg <= $signed(cfg_data);
                bbmc_pkg::REG_ANGLE_KD:   angle_kd_reg <= $signed(cfg_data);
                bbmc_pkg::REG_SPEED_KP:   speed_kp_reg <= $signed(cfg_data);
                bbmc_pkg::REG_SPEED_KI:   speed_ki_reg <= $signed(cfg_data);
                bbmc_pkg::REG_PITCH_SETP: setp_reg     <= $signed(cfg_data[16:0]);
                bbmc_pkg::REG_REAR_TGT:   target_reg   <= $signed(cfg_data[15:0]);
                bbmc_pkg::REG_RUN_EN:     run_reg      <= cfg_data[0];
            endcase
        end
    end

    // loop state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_int_reg <= '0;
            filt_reg      <= '0;
            sint_reg      <= '0;
            racc_reg      <= '0;
            rlast_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept_c)
            begin
                angle_int_reg <= ai_c;
                racc_reg      <= racc_c;
                rlast_reg     <= rb_c;
            end
            if (load_out_c)
            begin
                filt_reg <= run_reg ? f_reg : 32'sd0;
                sint_reg <= run_reg ? si_reg : 24'sd0;
            end
            if (load_out_c)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // word datapath
    always_ff @(posedge clk)
    begin
        if (accept_c)
        begin
            gyro_reg  <= sample.gyro_rate;
            enc_a_reg <= sample.encoder_a;
            steer_reg <= sample.steer_request;
            bias_reg  <= bias_c;
            ai_reg    <= ai_c;
            stop_reg  <= stop_c;
        end

        if ((state_reg == bbmc_pkg::ST_MUL_WAIT) && mul_rsp.done)
        begin
            unique case (step_reg)
                bbmc_pkg::STEP_KP:   acc_reg <= mul_rsp.product;
                bbmc_pkg::STEP_KI:   acc_reg <= acc_reg + mul_rsp.product;
                bbmc_pkg::STEP_KD:   ang_reg <= ang_c;
                bbmc_pkg::STEP_SKP:  acc_reg <= mul_rsp.product;
                bbmc_pkg::STEP_X100: acc_reg <= mul_rsp.product;
                bbmc_pkg::STEP_SKI:  acc_reg <= vsum_c;
                default:             acc_reg <= acc_reg;
            endcase
        end

        if (state_reg == bbmc_pkg::ST_DIV_GO)
        begin
            if (step_reg == bbmc_pkg::STEP_FDIV)
                neg_reg <= fnum_c[39];
            else
                neg_reg <= acc_reg[63];
        end

        if ((state_reg == bbmc_pkg::ST_DIV_WAIT) && div_rsp.done)
        begin
            if (step_reg == bbmc_pkg::STEP_FDIV)
                f_reg <= 32'(qs_c);
            else
                vel_reg <= qs_c;
        end

        // the integral follows the new filtered speed
        if ((state_reg == bbmc_pkg::ST_MUL_GO) && (step_reg == bbmc_pkg::STEP_SKP))
            si_reg <= si_c;

        if (load_out_c)
        begin
            duty_a_reg  <= stop_reg ? 14'sd0 : da_c;
            duty_b_reg  <= stop_reg ? 12'sd0 : db_c;
            pulse_reg   <= pulse_c;
            stopped_reg <= stop_reg;
        end
    end

    assign sample.ready       = (state_reg == bbmc_pkg::ST_IDLE);
    assign result.valid       = res_valid_reg;
    assign result.duty_a      = duty_a_reg;
    assign result.duty_b      = duty_b_reg;
    assign result.servo_pulse = pulse_reg;
    assign result.stopped     = stopped_reg;

endmodule

>>> bench/bbmc_tb_ifs.sv
// bench interface copies are not needed; the RTL interfaces are reused
// this file holds the bench-side sample and result word types used by checker and top
// depends on bbmc_pkg
`timescale 1ns / 1ps
package bbmc_tb_pkg;
    import bbmc_pkg::*;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [RAW16_W-1:0] gyro;
        logic signed [RAW16_W-1:0] enc_a;
        logic signed [RAW16_W-1:0] enc_b;
        logic        [BATT_W-1:0]  batt;
        logic signed [RAW16_W-1:0] steer;
    } sample_word_t;

    typedef struct packed {
        logic signed [DUTY_A_W-1:0] duty_a;
        logic signed [DUTY_B_W-1:0] duty_b;
        logic        [SERVO_W-1:0]  servo;
        logic                       stopped;
    } result_word_t;
endpackage

>>> bench/bbmc_checker.sv
// bbmc_checker: watches the sample, result and config ports, predicts each
// result word from its own controller model and compares field by field
// depends on bbmc_pkg, bbmc_tb_pkg and bbmc_ifs
`timescale 1ns / 1ps
module bbmc_checker
    import bbmc_pkg::*;
    import bbmc_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bbmc_sample_if                sample,
    bbmc_result_if                result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    words_seen,
    output int                    stops_seen
);
    longint gain [8];
    longint ang_int, filt, spd_int, rear_acc, rear_err;
    result_word_t expected_words [$];

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    // controller model: one tick per sample word
    function automatic result_word_t tick(sample_word_t s);
        result_word_t r;
        longint bias, asum, aterm, e, f, si, vel, da, pulse, rb, acc, db;
        logic stop;
        bias = longint'(s.pitch) - gain[REG_PITCH_SETP];
        ang_int = clip(ang_int + bias, -ANGLE_INT_LIM, ANGLE_INT_LIM);
        asum = gain[REG_ANGLE_KP] * bias + gain[REG_ANGLE_KI] * ang_int
             + gain[REG_ANGLE_KD] * longint'(s.gyro) * 256;
        aterm = asum / 65536;
        e = -longint'(s.enc_a);
        f = (7 * filt + 3 * e * 32768) / 10;
        si = clip(spd_int + f / 8, -SPEED_INT_LIM, SPEED_INT_LIM);
        vel = (f * gain[REG_SPEED_KP] * 100 + si * gain[REG_SPEED_KI] * 8)
            / (100 * 64'sd8388608);
        if (gain[REG_RUN_EN] == 0)
        begin
            f = 0;
            si = 0;
            vel = 0;
        end
        filt = f;
        spd_int = si;
        da = -aterm - vel;
        if (da > DUTY_A_LIM) da = DUTY_A_LIM;
        else if (da < -DUTY_A_LIM) da = -DUTY_A_LIM;
        else if (da < 0) da += DUTY_A_TRIM;
        else if (da > 0) da -= DUTY_A_TRIM;
        if (da < DUTY_A_DEAD && da > -DUTY_A_DEAD) da = 0;
        pulse = clip(SERVO_CENTER + clip(longint'(s.steer), -SERVO_LIMIT, SERVO_LIMIT),
                     0, 65535);
        rb = clip(longint'(s.enc_b) - gain[REG_REAR_TGT], -32768, 32767);
        acc = clip(rear_acc + REAR_KP * (rb - rear_err) + REAR_KI * rb,
                   -REAR_LIM, REAR_LIM);
        rear_acc = acc;
        rear_err = rb;
        db = acc / 5;
        stop = (s.batt < BATT_MIN) || (s.pitch > TILT_LIM) || (s.pitch < -TILT_LIM);
        if (stop)
        begin
            da = 0;
            db = 0;
        end
        r.duty_a = da[DUTY_A_W-1:0];
        r.duty_b = db[DUTY_B_W-1:0];
        r.servo = pulse[SERVO_W-1:0];
        r.stopped = stop;
        return r;
    endfunction

    // track config, predict on accepted samples, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        sample_word_t s;
        result_word_t got, want;
        if (!rst_n)
        begin
            gain[REG_ANGLE_KP] = 486400;
            gain[REG_ANGLE_KI] = -13261;
            gain[REG_ANGLE_KD] = 3840;
            gain[REG_SPEED_KP] = 8192;
            gain[REG_SPEED_KI] = 256;
            gain[REG_PITCH_SETP] = -179;
            gain[REG_REAR_TGT] = 30;
            gain[REG_RUN_EN] = 1;
            ang_int = 0; filt = 0; spd_int = 0; rear_acc = 0; rear_err = 0;
            errors = 0;
            words_seen = 0;
            stops_seen = 0;
            expected_words.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = '{result.duty_a, result.duty_b, result.servo_pulse, result.stopped};
                words_seen++;
                if (got.stopped) stops_seen++;
                if (expected_words.size() == 0)
                    report("unexpected word", 0, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (got.duty_a !== want.duty_a) report("duty_a", got.duty_a, want.duty_a);
                    if (got.duty_b !== want.duty_b) report("duty_b", got.duty_b, want.duty_b);
                    if (got.servo !== want.servo) report("servo_pulse", got.servo, want.servo);
                    if (got.stopped !== want.stopped)
                        report("stopped", got.stopped, want.stopped);
                end
            end
            if (sample.valid && sample.ready)
            begin
                s = '{sample.pitch_angle, sample.gyro_rate, sample.encoder_a,
                      sample.encoder_b, sample.battery_level, sample.steer_request};
                expected_words.push_back(tick(s));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PITCH_SETP: gain[cfg_index] = longint'($signed(cfg_data[16:0]));
                    REG_REAR_TGT:   gain[cfg_index] = longint'($signed(cfg_data[15:0]));
                    REG_RUN_EN:     gain[cfg_index] = cfg_data[0];
                    default:        gain[cfg_index] = longint'($signed(cfg_data));
                endcase
            end
        end
        pending = expected_words.size();
    end
endmodule

>>> bench/tb.sv
// tb: drives samples, config writes and result stalls into the controller,
// and gives the verdict from the checker's error and pending counts
// depends on bbmc_pkg, bbmc_tb_pkg, bbmc_ifs, bbmc_checker and the RTL
`timescale 1ns / 1ps
module tb;
    import bbmc_pkg::*;
    import bbmc_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ANGLE_KP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic hold_start = 1'b0;
    int errors, pending, words_seen, stops_seen;
    int send_idle_pct, recv_stall_pct;
    int sent;
    longint cycles;

    bbmc_sample_if sample ();
    bbmc_result_if result ();

    balance_bike_motor_controller dut (
        .clk(clk), .rst_n(rst_n), .sample(sample), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bbmc_checker chk (
        .clk(clk), .rst_n(rst_n), .sample(sample), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .words_seen(words_seen),
        .stops_seen(stops_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall, with one long hold-off counted here
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = 2000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // send one sample word, with a random idle gap first
    task automatic send_word(sample_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        {sample.pitch_angle, sample.gyro_rate, sample.encoder_a, sample.encoder_b,
         sample.battery_level, sample.steer_request} <= w;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic sample_word_t rand_word();
        sample_word_t w;
        int sel;
        sel = $urandom_range(9);
        w.gyro = (sel == 0) ? 16'($urandom()) : 16'($urandom_range(2000) - 1000);
        w.enc_a = (sel == 1) ? 16'($urandom()) : 16'($urandom_range(400) - 200);
        w.enc_b = (sel == 2) ? 16'($urandom()) : 16'($urandom_range(400) - 170);
        w.steer = (sel == 3) ? 16'($urandom()) : 16'($urandom_range(800) - 400);
        w.batt = (sel == 4) ? 12'($urandom()) : 12'($urandom_range(4095, 2400));
        w.pitch = (sel == 5) ? 17'($urandom_range(92160)) - 17'sd46080
                             : 17'($urandom_range(11000)) - 17'sd5500;
        return w;
    endfunction

    function automatic sample_word_t make(int p, int g, int ea, int eb, int b, int st);
        sample_word_t w;
        w = '{p[PITCH_W-1:0], g[15:0], ea[15:0], eb[15:0], b[BATT_W-1:0], st[15:0]};
        return w;
    endfunction

    initial
    begin
        int phase;
        sample.valid = 1'b0;
        {sample.pitch_angle, sample.gyro_rate, sample.encoder_a, sample.encoder_b,
         sample.battery_level, sample.steer_request} = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, stop cases, saturation, servo clamp
        send_word(make(0, 0, 0, 0, 4095, 0));
        send_word(make(46080, 32767, 32767, 32767, 4095, 32767));
        send_word(make(-46080, -32768, -32768, -32768, 0, -32768));
        send_word(make(5120, 0, 0, 30, 2500, 300));
        send_word(make(5121, 0, 0, 30, 3000, 301));
        send_word(make(-5121, 0, 0, 30, 3000, -301));
        send_word(make(-5120, 0, 0, 30, 2499, -300));
        send_word(make(2000, 5000, -100, 200, 4000, 10));
        send_word(make(-2000, -5000, 100, -200, 4000, -10));
        send_word(make(300, 100, 5, 40, 3500, 0));
        send_word(make(-300, -100, -5, 20, 3500, 0));
        send_word(make(0, 32767, -32768, -32768, 4095, 65535));
        send_word(make(0, -32768, 32767, 32767, 4095, 1));
        drain();

        // disable the velocity loop, extreme gains
        write_reg(REG_RUN_EN, 24'd0);
        write_reg(REG_ANGLE_KP, 24'h7FFFFF);
        write_reg(REG_ANGLE_KI, 24'h800000);
        write_reg(REG_ANGLE_KD, 24'h7FFFFF);
        write_reg(REG_SPEED_KP, 24'h800000);
        write_reg(REG_SPEED_KI, 24'h7FFFFF);
        write_reg(REG_PITCH_SETP, 24'(17'sd46080));
        write_reg(REG_REAR_TGT, 24'(16'sh8000));
        write_reg(REG_RUN_EN, 24'hFFFFFE);
        send_word(make(100, 10, 10, 32767, 3000, 5));
        send_word(make(-100, -10, -10, -32768, 3000, -5));
        send_word(make(0, 0, 50, 0, 3000, 0));
        drain();

        // random phases across settings and idle patterns
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (phase)
                0: begin
                    write_reg(REG_ANGLE_KP, 24'd486400);
                    write_reg(REG_ANGLE_KI, -24'sd13261);
                    write_reg(REG_ANGLE_KD, 24'd3840);
                    write_reg(REG_SPEED_KP, 24'd8192);
                    write_reg(REG_SPEED_KI, 24'd256);
                    write_reg(REG_PITCH_SETP, -24'sd179);
                    write_reg(REG_REAR_TGT, 24'd30);
                    write_reg(REG_RUN_EN, 24'd1);
                end
                3: begin
                    write_reg(REG_PITCH_SETP, 24'(-17'sd46080));
                    write_reg(REG_REAR_TGT, 24'h007FFF);
                    write_reg(REG_SPEED_KP, 24'h7FFFFF);
                    write_reg(REG_SPEED_KI, 24'h800000);
                end
                5: write_reg(REG_RUN_EN, 24'd0);
                6: begin
                    write_reg(REG_RUN_EN, 24'd1);
                    write_reg(REG_ANGLE_KP, 24'($urandom()));
                    write_reg(REG_ANGLE_KI, 24'($urandom()));
                    write_reg(REG_ANGLE_KD, 24'($urandom()));
                    write_reg(REG_SPEED_KP, 24'($urandom()));
                    write_reg(REG_SPEED_KI, 24'($urandom()));
                    write_reg(REG_PITCH_SETP, 24'($urandom_range(600)) - 24'd300);
                    write_reg(REG_REAR_TGT, 24'($urandom()));
                end
                default: ;
            endcase
            // long receiver hold-off while samples keep coming
            if (phase == 1)
                hold_start <= 1'b1;
            for (int n = 0; n < 240; n++)
            begin
                send_word(rand_word());
                // sender waits once, partway through phase 4, for everything to come back
                if (phase == 4 && n == 100)
                    drain();
            end
            drain();
        end

        $display("ran %0d sample words, %0d result words checked, %0d with stop forced",
                 sent, words_seen, stops_seen);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
